// ===== src/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

  localparam int HELD_DEPTH = 4;
  localparam int MAX_UNITS  = 4;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] unit_t;
  typedef logic [2:0]  len_t;
  typedef logic [2:0]  cnt_t;

  typedef byte_t [HELD_DEPTH-1:0] held_t;
  typedef unit_t [MAX_UNITS-1:0]  units_t;

  // Lead byte classes
  localparam byte_t LEAD5_MASK = 8'hFC;
  localparam byte_t LEAD5_CODE = 8'hF8;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_CODE = 8'hF0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_CODE = 8'hE0;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_CODE = 8'hC0;
  localparam byte_t CONT_MASK  = 8'h3F;
  localparam byte_t LEAD2_BITS = 8'h1F;

  localparam len_t LEN1 = 3'd1;
  localparam len_t LEN2 = 3'd2;
  localparam len_t LEN3 = 3'd3;
  localparam len_t LEN4 = 3'd4;
  localparam len_t LEN5 = 3'd5;

  localparam logic [25:0] PAIR_OFFSET = 26'h0010000;
  localparam unit_t       HI_SURR     = 16'hD800;
  localparam unit_t       LO_SURR     = 16'hDC00;

  typedef struct packed {
    unit_t hi;
    unit_t lo;
  } pair_t;

  // Result of decoding one accepted byte
  typedef struct packed {
    units_t units;
    cnt_t   n_units;
    logic   hold;
    cnt_t   hcnt_nxt;
    len_t   slen_nxt;
  } dec_out_t;

  function automatic len_t lead_len(byte_t b);
    len_t l;
    if ((b & LEAD5_MASK) == LEAD5_CODE)      l = LEN5;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) l = LEN4;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) l = LEN3;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) l = LEN2;
    else                                     l = LEN1;
    return l;
  endfunction

  function automatic unit_t unit2(byte_t b0, byte_t b1);
    byte_t lo0;
    byte_t lo1;
    lo0 = b0 & LEAD2_BITS;
    lo1 = b1 & CONT_MASK;
    return {5'd0, lo0[4:0], lo1[5:0]};
  endfunction

  function automatic unit_t unit3(byte_t b0, byte_t b1, byte_t b2);
    byte_t lo1;
    byte_t lo2;
    lo1 = b1 & CONT_MASK;
    lo2 = b2 & CONT_MASK;
    return {b0[3:0], lo1[5:0], lo2[5:0]};
  endfunction

  // Subtract the plane offset and split into high and low surrogates;
  // bits above 25 never reach the truncated halves.
  function automatic pair_t surrogate(logic [25:0] v);
    logic [25:0] h;
    pair_t       p;
    h    = v - PAIR_OFFSET;
    p.hi = h[25:10] + HI_SURR;
    p.lo = {6'd0, h[9:0]} + LO_SURR;
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== src/u8u16_ifs.sv =====
`default_nettype none

interface u8u16_in_if;
  logic                 valid;
  logic                 ready;
  u8u16_pkg::byte_t     in_byte;
  logic                 end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic                 valid;
  logic                 ready;
  u8u16_pkg::unit_t     code_unit;
  logic                 last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/u8u16_dec.sv =====
`default_nettype none

module u8u16_dec (
  input  wire u8u16_pkg::held_t    held,
  input  wire u8u16_pkg::cnt_t     held_cnt,
  input  wire u8u16_pkg::len_t     seq_len,
  input  wire u8u16_pkg::byte_t    in_byte,
  input  wire                      last,
  output u8u16_pkg::dec_out_t      dec
);

  u8u16_pkg::byte_t buf5 [5];
  u8u16_pkg::byte_t tl [3];
  u8u16_pkg::units_t u;
  u8u16_pkg::cnt_t   k;
  u8u16_pkg::len_t   l0;
  u8u16_pkg::len_t   l1;
  u8u16_pkg::pair_t  pr;
  logic [1:0]        p;
  logic [25:0]       v;
  logic [3:0]        n_all;
  u8u16_pkg::byte_t  m0;
  u8u16_pkg::byte_t  m1;
  u8u16_pkg::byte_t  m2;
  u8u16_pkg::byte_t  m3;
  u8u16_pkg::byte_t  m4;

  // Bytes of the open sequence with the new byte appended
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      buf5[i] = (3'(i) < held_cnt) ? held[i] : in_byte;
    end
    buf5[4] = in_byte;
    // Bytes after the lead, for the end-of-string re-decode
    for (int i = 0; i < 3; i++) begin
      tl[i] = (3'(i + 1) < held_cnt) ? held[i + 1] : in_byte;
    end
  end

  assign m0 = buf5[0];
  assign m1 = buf5[1] & u8u16_pkg::CONT_MASK;
  assign m2 = buf5[2] & u8u16_pkg::CONT_MASK;
  assign m3 = buf5[3] & u8u16_pkg::CONT_MASK;
  assign m4 = buf5[4] & u8u16_pkg::CONT_MASK;
  assign n_all = {1'b0, held_cnt} + 4'd1;

  always_comb begin
    u   = '0;
    k   = '0;
    p   = '0;
    v   = '0;
    pr  = '0;
    l0  = u8u16_pkg::lead_len(tl[0]);
    l1  = u8u16_pkg::lead_len(tl[1]);
    dec.hold     = 1'b0;
    dec.hcnt_nxt = held_cnt;
    dec.slen_nxt = seq_len;

    if (held_cnt == '0) begin
      if (u8u16_pkg::lead_len(in_byte) != u8u16_pkg::LEN1 && !last) begin
        dec.hold     = 1'b1;
        dec.hcnt_nxt = 3'd1;
        dec.slen_nxt = u8u16_pkg::lead_len(in_byte);
      end else begin
        u[k[1:0]] = {8'd0, in_byte};
        k = k + 3'd1;
      end
    end else if (n_all >= {1'b0, seq_len}) begin
      case (seq_len)
        u8u16_pkg::LEN5: begin
          v  = {m0[1:0], m1[5:0], m2[5:0], m3[5:0], m4[5:0]};
          pr = u8u16_pkg::surrogate(v);
          u[0] = pr.hi;
          u[1] = pr.lo;
          k = 3'd2;
        end
        u8u16_pkg::LEN4: begin
          v  = {5'd0, m0[2:0], m1[5:0], m2[5:0], m3[5:0]};
          pr = u8u16_pkg::surrogate(v);
          u[0] = pr.hi;
          u[1] = pr.lo;
          k = 3'd2;
        end
        u8u16_pkg::LEN3: begin
          u[0] = u8u16_pkg::unit3(buf5[0], buf5[1], buf5[2]);
          k = 3'd1;
        end
        u8u16_pkg::LEN2: begin
          u[0] = u8u16_pkg::unit2(buf5[0], buf5[1]);
          k = 3'd1;
        end
        default: begin
          u[0] = {8'd0, buf5[0]};
          k = 3'd1;
        end
      endcase
      dec.hcnt_nxt = '0;
      dec.slen_nxt = '0;
    end else if (last) begin
      // Emit the stranded lead, then re-decode up to three trailing bytes
      u[0] = {8'd0, buf5[0]};
      k = 3'd1;
      if (l0 == u8u16_pkg::LEN2 && held_cnt >= 3'd2) begin
        u[k[1:0]] = u8u16_pkg::unit2(tl[0], tl[1]);
        k = k + 3'd1;
        p = 2'd2;
      end else if (l0 == u8u16_pkg::LEN3 && held_cnt == 3'd3) begin
        u[k[1:0]] = u8u16_pkg::unit3(tl[0], tl[1], tl[2]);
        k = k + 3'd1;
        p = 2'd3;
      end else begin
        u[k[1:0]] = {8'd0, tl[0]};
        k = k + 3'd1;
        p = 2'd1;
      end
      if (p == 2'd1 && held_cnt >= 3'd2) begin
        if (l1 == u8u16_pkg::LEN2 && held_cnt == 3'd3) begin
          u[k[1:0]] = u8u16_pkg::unit2(tl[1], tl[2]);
          k = k + 3'd1;
          p = 2'd3;
        end else begin
          u[k[1:0]] = {8'd0, tl[1]};
          k = k + 3'd1;
          p = 2'd2;
        end
      end
      if (p == 2'd2 && held_cnt == 3'd3) begin
        u[k[1:0]] = {8'd0, tl[2]};
        k = k + 3'd1;
      end
      dec.hcnt_nxt = '0;
      dec.slen_nxt = '0;
    end else begin
      dec.hold     = 1'b1;
      dec.hcnt_nxt = n_all[2:0];
    end

    dec.units   = u;
    dec.n_units = k;
  end

endmodule

`default_nettype wire

// ===== src/utf8_to_utf16_decoder_top.sv =====
// Channel  | Role   | Payload                         | Handshake
// in_ch    | sink   | in_byte[7:0], end_of_string     | valid/ready
// out_ch   | source | code_unit[15:0], last_of_run    | valid/ready
//
// One byte is decoded in the cycle it is accepted; its units appear on out_ch
// from the next cycle, one unit per cycle while out_ch is ready.
// A byte that yields k units holds the result register until the last of them
// transfers; the next byte is taken in that cycle, so the rate is one byte
// per cycle while each byte yields at most one unit and out_ch is ready.
// Reset (rst_n low, synchronous) drops any open sequence and pending units.
// A stall on out_ch holds the result register and backs up into in_ch.
`default_nettype none

module utf8_to_utf16_decoder_top (
  input  wire         clk,
  input  wire         rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  u8u16_pkg::held_t    held_r;
  u8u16_pkg::cnt_t     hcnt_r;
  u8u16_pkg::len_t     slen_r;
  u8u16_pkg::units_t   units_r;
  u8u16_pkg::cnt_t     cnt_r;
  logic [1:0]          pos_r;
  u8u16_pkg::dec_out_t dec;
  logic                in_fire;
  logic                out_fire;
  logic                out_last;

  u8u16_dec u_dec (
    .held     (held_r),
    .held_cnt (hcnt_r),
    .seq_len  (slen_r),
    .in_byte  (in_ch.in_byte),
    .last     (in_ch.end_of_string),
    .dec      (dec)
  );

  assign out_last  = ({1'b0, pos_r} + 3'd1) == cnt_r;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == '0) || (out_fire && out_last);
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.code_unit   = units_r[pos_r];
  assign out_ch.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
      slen_r <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (in_fire) begin
        hcnt_r <= dec.hcnt_nxt;
        slen_r <= dec.slen_nxt;
      end
      if (in_fire && dec.n_units != '0) begin
        cnt_r <= dec.n_units;
        pos_r <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          cnt_r <= '0;
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && dec.hold) begin
      held_r[hcnt_r[1:0]] <= in_ch.in_byte;
    end
    if (in_fire && dec.n_units != '0) begin
      units_r <= dec.units;
    end
  end

endmodule

`default_nettype wire

// ===== src/u8u16_chk.sv =====
`default_nettype none

module u8u16_chk (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire u8u16_pkg::unit_t out_code_unit,
  input wire                   out_last_of_run
);

  // Hold a stalled unit until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_code_unit) && $stable(out_last_of_run))
    else $error("out payload changed while stalled");

  // A run continues until its last unit transfers
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("run ended without last_of_run");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_decoder_top u8u16_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_code_unit   (out_ch.code_unit),
  .out_last_of_run (out_ch.last_of_run)
);

`default_nettype wire

// ===== tb/u8u16_checker.sv =====
`default_nettype none

module u8u16_checker (
  input  wire  clk,
  input  wire  rst_n,
  u8u16_in_if  in_mon,
  u8u16_out_if out_mon,
  output int   fail_count,
  output int   units_waiting,
  output int   units_checked,
  output int   strings_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    u8u16_pkg::unit_t code;
    logic             last;
  } coded_unit_t;

  coded_unit_t      want_q[$];
  u8u16_pkg::byte_t open_bytes [u8u16_pkg::HELD_DEPTH];
  int               open_count;
  int               open_len;

  function automatic int seq_len(u8u16_pkg::byte_t b);
    casez (b)
      8'b1111_10??: return 5;
      8'b1111_0???: return 4;
      8'b1110_????: return 3;
      8'b110?_????: return 2;
      default:      return 1;
    endcase
  endfunction

  function automatic void push_unit(u8u16_pkg::unit_t u);
    coded_unit_t item;
    item.code = u;
    item.last = 1'b0;
    want_q.insert(want_q.size(), item);
  endfunction

  // Offset and split wrap modulo 32 bits, halves truncated to 16.
  function automatic void push_pair(logic [31:0] v);
    logic [31:0] h;
    logic [31:0] hi;
    logic [31:0] lo;
    h  = v - 32'h0001_0000;
    hi = (h >> 10) + 32'h0000_D800;
    lo = (h & 32'h0000_03FF) + 32'h0000_DC00;
    push_unit(hi[15:0]);
    push_unit(lo[15:0]);
  endfunction

  function automatic void decode_full(input u8u16_pkg::byte_t s [5], input int len);
    case (len)
      5: push_pair({6'd0, s[0][1:0], s[1][5:0], s[2][5:0], s[3][5:0], s[4][5:0]});
      4: push_pair({11'd0, s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]});
      3: push_unit({s[0][3:0], s[1][5:0], s[2][5:0]});
      2: push_unit({5'd0, s[0][4:0], s[1][5:0]});
      default: push_unit({8'd0, s[0]});
    endcase
  endfunction

  // Decode s[first..n-1] knowing that nothing follows; short leads go out alone.
  function automatic void decode_tail(input u8u16_pkg::byte_t s [5], input int first,
                                      input int n);
    u8u16_pkg::byte_t part [5];
    int               i;
    int               len;
    i = first;
    while (i < n) begin
      len = seq_len(s[i]);
      if (len > 1 && i + len <= n) begin
        for (int k = 0; k < 5; k++) part[k] = (i + k < 5) ? s[i + k] : 8'h00;
        decode_full(part, len);
        i += len;
      end else begin
        push_unit({8'd0, s[i]});
        i++;
      end
    end
  endfunction

  function automatic void transcode_byte(u8u16_pkg::byte_t b, logic eos);
    u8u16_pkg::byte_t run [5];
    int               n;
    int               len;
    int               size_before;
    size_before = want_q.size();
    for (int k = 0; k < 5; k++) run[k] = 8'h00;
    n = open_count;
    for (int k = 0; k < n; k++) run[k] = open_bytes[k];
    run[n] = b;
    n++;
    if (n == 1) begin
      len = seq_len(b);
      if (len > 1 && !eos) begin
        open_bytes[0] = b;
        open_count    = 1;
        open_len      = len;
      end else begin
        push_unit({8'd0, b});
      end
    end else if (n >= open_len) begin
      decode_full(run, open_len);
      open_count = 0;
      open_len   = 0;
    end else if (eos) begin
      push_unit({8'd0, run[0]});
      decode_tail(run, 1, n);
      open_count = 0;
      open_len   = 0;
    end else begin
      open_bytes[n - 1] = b;
      open_count        = n;
    end
    if (want_q.size() > size_before) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_miss(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    coded_unit_t want;
    if (!rst_n) begin
      want_q.delete();
      open_count = 0;
      open_len   = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        units_checked++;
        if (want_q.size() == 0) begin
          report_miss($sformatf("unit %h last %b with nothing expected",
                                out_mon.code_unit, out_mon.last_of_run));
        end else begin
          want = want_q.pop_front();
          if (out_mon.code_unit !== want.code)
            report_miss($sformatf("code_unit expected %h got %h",
                                  want.code, out_mon.code_unit));
          if (out_mon.last_of_run !== want.last)
            report_miss($sformatf("last_of_run expected %b got %b (unit %h)",
                                  want.last, out_mon.last_of_run, want.code));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        transcode_byte(in_mon.in_byte, in_mon.end_of_string);
        if (in_mon.end_of_string) strings_seen++;
      end
    end
    units_waiting = want_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STIM_BYTES   = 400;
  localparam int QUIET_FROM   = 340;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED   = 25;

  // {end_of_string, byte}: extremes, every length, short and cut strings
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    9'h000, 9'h1FF,
    9'h0C2, 9'h1A9,
    9'h0EF, 9'h0BF, 9'h1BF,
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    9'h0F8, 9'h080, 9'h080, 9'h080, 9'h180,
    9'h1E2,
    9'h0F0, 9'h0E1, 9'h180,
    9'h0FB, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   bytes_sent = 0;
  bit   quiet = 1'b0;

  int fail_count;
  int units_waiting;
  int units_checked;
  int strings_seen;

  u8u16_in_if  in_ch();
  u8u16_out_if out_ch();

  utf8_to_utf16_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  u8u16_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .units_waiting (units_waiting),
    .units_checked (units_checked),
    .strings_seen  (strings_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d units outstanding", cycles, units_waiting);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall the result side in bursts until the quiet tail of the run.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic u8u16_pkg::byte_t cont_byte();
    u8u16_pkg::byte_t r;
    r = u8u16_pkg::byte_t'($urandom);
    if ($urandom_range(0, 9) != 0) r = {2'b10, r[5:0]};
    return r;
  endfunction

  function automatic u8u16_pkg::byte_t lead_byte(int nbytes);
    u8u16_pkg::byte_t r;
    r = u8u16_pkg::byte_t'($urandom);
    case (nbytes)
      5: r = {6'b111110, r[1:0]};
      4: r = {5'b11110, r[2:0]};
      3: r = {4'b1110, r[3:0]};
      2: r = {3'b110, r[4:0]};
      default: begin
        case ($urandom_range(0, 3))
          0, 1: r = {1'b0, r[6:0]};
          2:    r = {2'b10, r[5:0]};
          default: r = {6'b111111, r[1:0]};
        endcase
      end
    endcase
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input u8u16_pkg::byte_t b, input logic eos);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.in_byte       = b;
    in_ch.end_of_string = eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  initial begin
    u8u16_pkg::byte_t text[$];
    int               mode;
    int               cls;
    int               cut;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_string = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    // Mostly well-formed strings, some cut short, some plain noise.
    while (bytes_sent < STIM_BYTES) begin
      text.delete();
      mode = $urandom_range(0, 9);
      if (mode >= 8) begin
        repeat ($urandom_range(1, 6)) text.insert(text.size(), u8u16_pkg::byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          cls = $urandom_range(1, 5);
          text.insert(text.size(), lead_byte(cls));
          repeat (cls - 1) text.insert(text.size(), cont_byte());
        end
        if (mode == 7) begin
          cut = $urandom_range(1, 3);
          while (cut > 0 && text.size() > 1) begin
            void'(text.pop_back());
            cut--;
          end
        end
      end
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    end
    in_ch.valid = 1'b0;

    while (units_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d bytes (%0d directed) in %0d strings; %0d code units checked",
             bytes_sent, N_DIRECTED, strings_seen, units_checked);
    $display("Mismatches: %0d, units still outstanding: %0d", fail_count, units_waiting);
    if (fail_count == 0 && units_waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
